[rtl/pcsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsa_pkg
// Beat types, search token, cell update command and the compare word function
// shared by the PWM channel slot allocator.
// ----------------------------------------------------------------------------
package pcsa_pkg;

    localparam int POS_W = 3;

    localparam logic [15:0] POL_NORMAL = 16'h8000;
    localparam logic [15:0] CMP_MAX    = 16'h7FFF;
    localparam logic [3:0]  RES_RESET  = 4'd8;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_STOP  = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  pin;
        logic        pin_eligible;
        logic [15:0] duty;
    } in_beat_t;

    typedef struct packed {
        logic        ok;
        logic [1:0]  instance_index;
        logic [1:0]  channel_index;
        logic [15:0] compare_word;
        logic        newly_assigned;
        logic        reconfigure;
        logic        instance_active;
    } out_beat_t;

    typedef struct packed {
        logic             valid;
        logic [7:0]       pin;
        logic             held_found;
        logic [POS_W-1:0] held_inst;
        logic [POS_W-1:0] held_ch;
        logic             free_found;
        logic [POS_W-1:0] free_inst;
        logic [POS_W-1:0] free_ch;
        logic             cur_other;
        logic             held_other;
    } token_t;

    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] inst;
        logic [POS_W-1:0] ch;
        logic             used;
        logic [7:0]       pin;
    } upd_t;

    function automatic logic [15:0] make_word(input logic [15:0] duty,
                                              input logic [3:0] res);
        logic [15:0] top;
        logic [15:0] word;
        top = 16'((17'd1 << res) - 17'd1);
        if (duty == 16'd0) begin
            word = POL_NORMAL;
        end else if (duty >= top) begin
            word = CMP_MAX | POL_NORMAL;
        end else begin
            word = duty | POL_NORMAL;
        end
        return word;
    endfunction

endpackage

[rtl/pcsa_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsa_cell
// One channel slot: holds the used flag and pin, checks the passing search
// token against them and hands the token to the next slot.
// ----------------------------------------------------------------------------
module pcsa_cell #(
    parameter int INST_IDX = 0,
    parameter int CH_IDX   = 0,
    parameter int LAST_CH  = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  pcsa_pkg::token_t  tok_in,
    output pcsa_pkg::token_t  tok_out,
    input  pcsa_pkg::upd_t    upd
);
    import pcsa_pkg::*;

    localparam logic [POS_W-1:0] MY_INST = POS_W'(INST_IDX);
    localparam logic [POS_W-1:0] MY_CH   = POS_W'(CH_IDX);

    logic       used_reg;
    logic       used_next;
    logic [7:0] pin_reg;
    logic [7:0] pin_next;
    token_t     tok_reg;
    token_t     tok_next;
    logic       match;
    logic       sel;

    assign match = used_reg && (pin_reg == tok_in.pin);
    assign sel   = upd.we && (upd.inst == MY_INST) && (upd.ch == MY_CH);

    always_comb begin
        tok_next = tok_in;
        if (CH_IDX == 0) begin
            tok_next.cur_other = used_reg && !match;
        end else begin
            tok_next.cur_other = tok_in.cur_other | (used_reg && !match);
        end
        if (match && !tok_in.held_found) begin
            tok_next.held_found = 1'b1;
            tok_next.held_inst  = MY_INST;
            tok_next.held_ch    = MY_CH;
        end
        if (!used_reg && !tok_in.free_found) begin
            tok_next.free_found = 1'b1;
            tok_next.free_inst  = MY_INST;
            tok_next.free_ch    = MY_CH;
        end
        // close out the instance: remember whether the held slot has company
        if ((LAST_CH != 0) && tok_next.held_found && (tok_next.held_inst == MY_INST)) begin
            tok_next.held_other = tok_next.cur_other;
        end
    end

    always_comb begin
        used_next = used_reg;
        pin_next  = pin_reg;
        if (sel) begin
            used_next = upd.used;
            if (upd.used) begin
                pin_next = upd.pin;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        pin_reg <= pin_next;
    end

    assign tok_out = tok_reg;

endmodule

[rtl/pcsa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcsa_ctrl
// Request sequencer: takes a command beat, launches the search token into the
// slot chain, decides the outcome, updates the chosen slot and holds the result.
// ----------------------------------------------------------------------------
module pcsa_ctrl #(
    parameter int PIN_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pcsa_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pcsa_pkg::out_beat_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data,
    output pcsa_pkg::token_t    tok_launch,
    input  pcsa_pkg::token_t    tok_end,
    output pcsa_pkg::upd_t      upd
);
    import pcsa_pkg::*;

    localparam logic [7:0] PIN_MASK =
        (PIN_BITS >= 8) ? 8'hFF : 8'((17'd1 << PIN_BITS) - 17'd1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

    state_t    state_reg,  state_next;
    logic      cmd_reg,    cmd_next;
    logic      elig_reg,   elig_next;
    logic [15:0] duty_reg, duty_next;
    logic [7:0]  pin_reg,  pin_next;
    logic [3:0]  res_reg,  res_next;
    token_t    tok_reg,    tok_next;
    token_t    end_reg,    end_next;
    logic      m_valid_reg, m_valid_next;
    out_beat_t m_data_reg,  m_data_next;

    out_beat_t result;
    upd_t      upd_c;
    logic      out_free;
    logic      accept;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // outcome of the finished search
    always_comb begin
        result = '0;
        upd_c  = '0;
        upd_c.pin = pin_reg;
        case (cmd_reg)
            CMD_WRITE: begin
                if (elig_reg && end_reg.held_found) begin
                    result.ok              = 1'b1;
                    result.instance_index  = end_reg.held_inst[1:0];
                    result.channel_index   = end_reg.held_ch[1:0];
                    result.compare_word    = make_word(duty_reg, res_reg);
                    result.instance_active = 1'b1;
                end else if (elig_reg && end_reg.free_found) begin
                    result.ok              = 1'b1;
                    result.instance_index  = end_reg.free_inst[1:0];
                    result.channel_index   = end_reg.free_ch[1:0];
                    result.compare_word    = make_word(duty_reg, res_reg);
                    result.newly_assigned  = 1'b1;
                    result.reconfigure     = 1'b1;
                    result.instance_active = 1'b1;
                    upd_c.we   = 1'b1;
                    upd_c.inst = end_reg.free_inst;
                    upd_c.ch   = end_reg.free_ch;
                    upd_c.used = 1'b1;
                end
            end
            CMD_STOP: begin
                if (end_reg.held_found) begin
                    result.ok              = 1'b1;
                    result.instance_index  = end_reg.held_inst[1:0];
                    result.channel_index   = end_reg.held_ch[1:0];
                    result.compare_word    = POL_NORMAL;
                    result.reconfigure     = end_reg.held_other;
                    result.instance_active = end_reg.held_other;
                    upd_c.we   = 1'b1;
                    upd_c.inst = end_reg.held_inst;
                    upd_c.ch   = end_reg.held_ch;
                    upd_c.used = 1'b0;
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        elig_next    = elig_reg;
        duty_next    = duty_reg;
        pin_next     = pin_reg;
        res_next     = res_reg;
        tok_next     = '0;
        end_next     = end_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        upd          = '0;

        if (cfg_valid && (cfg_data != 4'd0)) begin
            res_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd_next     = s_data.command;
                    elig_next    = s_data.pin_eligible;
                    duty_next    = s_data.duty;
                    pin_next     = s_data.pin & PIN_MASK;
                    tok_next.valid = 1'b1;
                    tok_next.pin   = s_data.pin & PIN_MASK;
                    state_next   = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (tok_end.valid) begin
                    end_next   = tok_end;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                    upd          = upd_c;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            res_reg     <= RES_RESET;
            tok_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            tok_reg     <= tok_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        elig_reg   <= elig_next;
        duty_reg   <= duty_next;
        pin_reg    <= pin_next;
        end_reg    <= end_next;
        m_data_reg <= m_data_next;
    end

    assign tok_launch = tok_reg;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

endmodule

[rtl/pwm_channel_slot_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_channel_slot_allocator_core
// PWM channel slot allocator: a chain of slot cells walked by a search token,
// instance-major, followed by a decision and at most one slot update.
// ----------------------------------------------------------------------------
// path: launch token register, each slot cell's token register, end_reg, then the output register
// a new beat is taken only in ST_IDLE, after the previous result is registered;
//   the token walks the slot chain one cell per cycle
// a finished result waits in the output register while the next beat searches
// reset: synchronous active low, all slots free, resolution 8, no beat pending
module pwm_channel_slot_allocator_core #(
    parameter int INSTANCES = 3,
    parameter int CHANNELS  = 4,
    parameter int PIN_BITS  = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pcsa_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pcsa_pkg::out_beat_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data
);
    import pcsa_pkg::*;

    localparam int SLOTS = INSTANCES * CHANNELS;

    token_t tok [0:SLOTS];
    upd_t   upd;

    pcsa_ctrl #(
        .PIN_BITS(PIN_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .tok_launch(tok[0]),
        .tok_end   (tok[SLOTS]),
        .upd       (upd)
    );

    for (genvar i = 0; i < SLOTS; i++) begin : g_slot
        pcsa_cell #(
            .INST_IDX(i / CHANNELS),
            .CH_IDX  (i % CHANNELS),
            .LAST_CH ((i % CHANNELS) == (CHANNELS - 1))
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .tok_in (tok[i]),
            .tok_out(tok[i+1]),
            .upd    (upd)
        );
    end

    // one request in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("beat accepted while a search is in flight");

    // failed requests report nothing else
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.ok) |-> (m_data.compare_word == 16'd0 &&
            !m_data.newly_assigned && !m_data.reconfigure && !m_data.instance_active))
        else $error("failed result carries data");

    // normal polarity bit always set on success
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.ok) |-> m_data.compare_word[15])
        else $error("compare word lost polarity bit");

    // a fresh channel always restarts a running instance
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.newly_assigned) |-> (m_data.ok && m_data.reconfigure &&
            m_data.instance_active))
        else $error("new channel without reconfigure");

    // reconfigure only where the instance stays active
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.reconfigure) |-> m_data.instance_active)
        else $error("reconfigure of a stopped instance");

endmodule
